// ===== src/tpp_pkg.sv =====
// shared types, codes and constants of the transfer packet parser
package tpp_pkg;

	// default number of file size bytes kept
	localparam int SIZE_BYTES_DEF = 8;
	// width of the file size result field
	localparam int TOTAL_SIZE_W = 64;

	// result queue geometry
	localparam int Q_DEPTH = 4;
	localparam int Q_AW = 2;
	localparam int Q_CW = 3;

	// configuration register indexes
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_DATA_CODE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_START_CODE = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_END_CODE = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SIZE_TYPE = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_NAME_TYPE = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_PAYLOAD = 3'd5;

	// configuration reset values
	localparam logic [7:0] DATA_CODE_RST = 8'd1;
	localparam logic [7:0] START_CODE_RST = 8'd2;
	localparam logic [7:0] END_CODE_RST = 8'd3;
	localparam logic [7:0] SIZE_TYPE_RST = 8'd0;
	localparam logic [7:0] NAME_TYPE_RST = 8'd1;
	localparam logic [15:0] MAX_PAYLOAD_RST = 16'hFFFF;

	// packet kinds (also op codes)
	localparam logic [1:0] PK_DATA = 2'd0;
	localparam logic [1:0] PK_START = 2'd1;
	localparam logic [1:0] PK_END = 2'd2;

	// result kinds
	localparam logic [1:0] RK_PAYLOAD = 2'd0;
	localparam logic [1:0] RK_NAME = 2'd1;
	localparam logic [1:0] RK_STATUS = 2'd2;

	// status codes
	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_BAD_CTRL = 2'd1;
	localparam logic [1:0] ST_OUT_OF_ORDER = 2'd2;
	localparam logic [1:0] ST_OVERFLOW = 2'd3;

	// header byte positions of a data packet
	localparam logic [1:0] HDR_SEQ = 2'd1;
	localparam logic [1:0] HDR_LEN_HI = 2'd2;
	localparam logic [1:0] HDR_LEN_LO = 2'd3;

	// parser phases
	typedef enum logic [2:0] {
		PH_IDLE,
		PH_DHDR,
		PH_DPAY,
		PH_CTYPE,
		PH_CLEN,
		PH_CVAL,
		PH_SKIP
	} phase_t;

	// one input request
	typedef struct packed {
		logic [1:0] op;
		logic [7:0] in_byte;
		logic       first;
		logic       last;
		logic [7:0] expected_seq;
	} pkt_t;

	// one result item
	typedef struct packed {
		logic [1:0]              kind;
		logic [7:0]              out_byte;
		logic [1:0]              status;
		logic [1:0]              packet_kind;
		logic [15:0]             data_length;
		logic [TOTAL_SIZE_W-1:0] total_size;
		logic                    end_of_packet;
	} res_t;

	// configuration register set
	typedef struct packed {
		logic [7:0]  data_code;
		logic [7:0]  start_code;
		logic [7:0]  end_code;
		logic [7:0]  size_type;
		logic [7:0]  name_type;
		logic [15:0] max_payload;
	} cfg_t;

	// results of one parsed byte, pushed into the result queue
	typedef struct packed {
		logic byte_valid;
		logic stat_valid;
		res_t byte_res;
		res_t stat_res;
	} push_t;

endpackage

// ===== src/transfer_packet_parser.sv =====
// top level of the transfer packet parser: input register, configuration, parser, result queue
// The parser takes one packet byte per clock while pkt_stall is low and answers on the res
// channel. A byte moves from the input register through the parser into a four-entry result
// queue; its results are written there when the byte leaves the input register. A byte
// gives at most one result, except a last byte that also carries a payload or file name
// byte, which gives two; such a byte always has header bytes that give no result ahead of
// it, so with the output side never stalled the parser takes one byte per cycle. The input
// register waits while the queue holds more than two results.
// Configuration writes are always ready and must only be made while no request is in flight.
module transfer_packet_parser #(
	parameter int SIZE_BYTES = tpp_pkg::SIZE_BYTES_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            pkt_valid,
	output logic                            pkt_stall,
	input  tpp_pkg::pkt_t                   pkt,
	output logic                            res_valid,
	input  logic                            res_stall,
	output tpp_pkg::res_t                   res,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [tpp_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [15:0]                     cfg_data
);

	tpp_pkg::cfg_t  cfg_q;
	tpp_pkg::pkt_t  pkt_s1;
	logic           valid_s1;
	logic           room;
	logic           fire;
	logic           load;
	tpp_pkg::push_t push;

	// input register handshake
	assign cfg_ready = 1'b1;
	assign fire = valid_s1 & room;
	assign pkt_stall = valid_s1 & ~fire;
	assign load = pkt_valid & ~pkt_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			pkt_s1 <= pkt;
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.data_code <= tpp_pkg::DATA_CODE_RST;
			cfg_q.start_code <= tpp_pkg::START_CODE_RST;
			cfg_q.end_code <= tpp_pkg::END_CODE_RST;
			cfg_q.size_type <= tpp_pkg::SIZE_TYPE_RST;
			cfg_q.name_type <= tpp_pkg::NAME_TYPE_RST;
			cfg_q.max_payload <= tpp_pkg::MAX_PAYLOAD_RST;
		end else if (cfg_valid & cfg_ready) begin
			unique case (cfg_index)
				tpp_pkg::REG_DATA_CODE: cfg_q.data_code <= cfg_data[7:0];
				tpp_pkg::REG_START_CODE: cfg_q.start_code <= cfg_data[7:0];
				tpp_pkg::REG_END_CODE: cfg_q.end_code <= cfg_data[7:0];
				tpp_pkg::REG_SIZE_TYPE: cfg_q.size_type <= cfg_data[7:0];
				tpp_pkg::REG_NAME_TYPE: cfg_q.name_type <= cfg_data[7:0];
				tpp_pkg::REG_MAX_PAYLOAD: cfg_q.max_payload <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	tpp_core #(
		.SIZE_BYTES(SIZE_BYTES)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.pkt_s1 (pkt_s1),
		.cfg    (cfg_q),
		.push   (push)
	);

	tpp_resq u_resq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.room      (room),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res)
	);

endmodule

// ===== src/tpp_core.sv =====
// byte parser: packet state and the results of one byte
module tpp_core #(
	parameter int SIZE_BYTES = tpp_pkg::SIZE_BYTES_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          fire,
	input  tpp_pkg::pkt_t pkt_s1,
	input  tpp_pkg::cfg_t cfg,
	output tpp_pkg::push_t push
);

	localparam int SW = SIZE_BYTES * 8;

	tpp_pkg::phase_t phase_q, phase_n;
	logic [1:0]  hidx_q, hidx_n;
	logic [15:0] plen_q, plen_n;
	logic [15:0] pcnt_q, pcnt_n;
	logic [7:0]  ftype_q, ftype_n;
	logic [7:0]  frem_q, frem_n;
	logic [7:0]  fpos_q, fpos_n;
	logic [SW-1:0] size_q, size_n;
	logic [1:0]  err_q, err_n;
	logic [1:0]  ckind_q, ckind_n;
	logic [7:0]  seq_q, seq_n;

	logic        byte_hit;
	logic [1:0]  byte_kind;
	logic        stat_hit;
	logic [7:0]  ctrl_code;
	logic [15:0] len_full;

	// next packet state for the byte in the input register
	always_comb begin
		phase_n = phase_q;
		hidx_n = hidx_q;
		plen_n = plen_q;
		pcnt_n = pcnt_q;
		ftype_n = ftype_q;
		frem_n = frem_q;
		fpos_n = fpos_q;
		size_n = size_q;
		err_n = err_q;
		ckind_n = ckind_q;
		seq_n = seq_q;
		byte_hit = 1'b0;
		byte_kind = tpp_pkg::RK_PAYLOAD;
		stat_hit = 1'b0;
		ctrl_code = cfg.end_code;
		len_full = {plen_q[15:8], pkt_s1.in_byte};
		if (pkt_s1.first) begin
			// a first byte always opens a new packet
			hidx_n = 2'd0;
			ftype_n = 8'd0;
			frem_n = 8'd0;
			fpos_n = 8'd0;
			plen_n = 16'd0;
			pcnt_n = 16'd0;
			size_n = '0;
			err_n = tpp_pkg::ST_OK;
			ckind_n = (pkt_s1.op >= tpp_pkg::PK_END) ? tpp_pkg::PK_END : pkt_s1.op;
			seq_n = pkt_s1.expected_seq;
			if (ckind_n == tpp_pkg::PK_DATA) begin
				if (pkt_s1.in_byte == cfg.data_code) begin
					phase_n = tpp_pkg::PH_DHDR;
					hidx_n = tpp_pkg::HDR_SEQ;
				end else begin
					err_n = tpp_pkg::ST_BAD_CTRL;
					phase_n = tpp_pkg::PH_SKIP;
				end
			end else begin
				ctrl_code = (ckind_n == tpp_pkg::PK_START) ? cfg.start_code : cfg.end_code;
				if (pkt_s1.in_byte == ctrl_code) begin
					phase_n = tpp_pkg::PH_CTYPE;
				end else begin
					err_n = tpp_pkg::ST_BAD_CTRL;
					phase_n = tpp_pkg::PH_SKIP;
				end
			end
		end else begin
			unique case (phase_q)
				tpp_pkg::PH_IDLE: begin
				end
				tpp_pkg::PH_DHDR: begin
					if (hidx_q == tpp_pkg::HDR_SEQ) begin
						if (pkt_s1.in_byte != seq_q) begin
							err_n = tpp_pkg::ST_OUT_OF_ORDER;
							phase_n = tpp_pkg::PH_SKIP;
						end else begin
							hidx_n = tpp_pkg::HDR_LEN_HI;
						end
					end else if (hidx_q == tpp_pkg::HDR_LEN_HI) begin
						plen_n = {pkt_s1.in_byte, 8'd0};
						hidx_n = tpp_pkg::HDR_LEN_LO;
					end else begin
						plen_n = len_full;
						if (len_full > cfg.max_payload) begin
							err_n = tpp_pkg::ST_OVERFLOW;
							phase_n = tpp_pkg::PH_SKIP;
						end else begin
							phase_n = tpp_pkg::PH_DPAY;
						end
					end
				end
				tpp_pkg::PH_DPAY: begin
					// bytes beyond the length are dropped
					if (pcnt_q < plen_q) begin
						byte_hit = 1'b1;
						byte_kind = tpp_pkg::RK_PAYLOAD;
						pcnt_n = pcnt_q + 16'd1;
					end
				end
				tpp_pkg::PH_CTYPE: begin
					ftype_n = pkt_s1.in_byte;
					phase_n = tpp_pkg::PH_CLEN;
				end
				tpp_pkg::PH_CLEN: begin
					frem_n = pkt_s1.in_byte;
					fpos_n = 8'd0;
					phase_n = (pkt_s1.in_byte != 8'd0) ? tpp_pkg::PH_CVAL : tpp_pkg::PH_CTYPE;
				end
				tpp_pkg::PH_CVAL: begin
					// size bytes land little-endian, later bytes past the store are dropped
					if (ftype_q == cfg.size_type) begin
						for (int i = 0; i < SIZE_BYTES; i++) begin
							if (fpos_q == 8'(i)) begin
								size_n[8*i +: 8] = pkt_s1.in_byte;
							end
						end
					end else if (ftype_q == cfg.name_type) begin
						byte_hit = 1'b1;
						byte_kind = tpp_pkg::RK_NAME;
					end
					if (fpos_q != 8'hFF) begin
						fpos_n = fpos_q + 8'd1;
					end
					frem_n = frem_q - 8'd1;
					if (frem_n == 8'd0) begin
						phase_n = tpp_pkg::PH_CTYPE;
					end
				end
				tpp_pkg::PH_SKIP: begin
				end
				default: begin
				end
			endcase
		end
		// last byte closes the packet unless none was open
		if (pkt_s1.last && (pkt_s1.first || phase_q != tpp_pkg::PH_IDLE)) begin
			if (err_n == tpp_pkg::ST_OK && ckind_n == tpp_pkg::PK_DATA) begin
				if (phase_n == tpp_pkg::PH_DHDR ||
				    (phase_n == tpp_pkg::PH_DPAY && pcnt_n < plen_n)) begin
					err_n = tpp_pkg::ST_OVERFLOW;
				end
			end
			stat_hit = 1'b1;
			phase_n = tpp_pkg::PH_IDLE;
		end
	end

	// result items of this byte
	always_comb begin
		push.byte_valid = fire & byte_hit;
		push.stat_valid = fire & stat_hit;
		push.byte_res.kind = byte_kind;
		push.byte_res.out_byte = pkt_s1.in_byte;
		push.byte_res.status = tpp_pkg::ST_OK;
		push.byte_res.packet_kind = ckind_n;
		push.byte_res.data_length = 16'd0;
		push.byte_res.total_size = '0;
		push.byte_res.end_of_packet = 1'b0;
		push.stat_res.kind = tpp_pkg::RK_STATUS;
		push.stat_res.out_byte = 8'd0;
		push.stat_res.status = err_n;
		push.stat_res.packet_kind = ckind_n;
		push.stat_res.end_of_packet = 1'b1;
		if (ckind_n == tpp_pkg::PK_DATA) begin
			push.stat_res.data_length = plen_n;
			push.stat_res.total_size = '0;
		end else begin
			push.stat_res.data_length = 16'd0;
			push.stat_res.total_size = tpp_pkg::TOTAL_SIZE_W'(size_n);
		end
	end

	// packet state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= tpp_pkg::PH_IDLE;
			hidx_q <= 2'd0;
			plen_q <= 16'd0;
			pcnt_q <= 16'd0;
			ftype_q <= 8'd0;
			frem_q <= 8'd0;
			fpos_q <= 8'd0;
			size_q <= '0;
			err_q <= tpp_pkg::ST_OK;
			ckind_q <= tpp_pkg::PK_DATA;
			seq_q <= 8'd0;
		end else if (fire) begin
			phase_q <= phase_n;
			hidx_q <= hidx_n;
			plen_q <= plen_n;
			pcnt_q <= pcnt_n;
			ftype_q <= ftype_n;
			frem_q <= frem_n;
			fpos_q <= fpos_n;
			size_q <= size_n;
			err_q <= err_n;
			ckind_q <= ckind_n;
			seq_q <= seq_n;
		end
	end

endmodule

// ===== src/tpp_resq.sv =====
// result queue: takes up to two results a cycle, hands out one while res_stall is low
module tpp_resq (
	input  logic           clk,
	input  logic           arst_n,
	input  tpp_pkg::push_t push,
	output logic           room,
	output logic           res_valid,
	input  logic           res_stall,
	output tpp_pkg::res_t  res
);

	tpp_pkg::res_t ent_q [tpp_pkg::Q_DEPTH];
	logic [tpp_pkg::Q_AW-1:0] wr_q;
	logic [tpp_pkg::Q_AW-1:0] rd_q;
	logic [tpp_pkg::Q_CW-1:0] cnt_q;
	logic [tpp_pkg::Q_CW-1:0] push_n;
	logic                     pop;
	tpp_pkg::res_t            ent0;

	// room for the worst case of two results
	assign room = cnt_q <= tpp_pkg::Q_CW'(tpp_pkg::Q_DEPTH - 2);
	assign res_valid = cnt_q != '0;
	assign res = ent_q[rd_q];
	assign pop = res_valid & ~res_stall;
	assign push_n = tpp_pkg::Q_CW'(push.byte_valid) + tpp_pkg::Q_CW'(push.stat_valid);
	assign ent0 = push.byte_valid ? push.byte_res : push.stat_res;

	// entry storage, byte result ahead of the status
	always_ff @(posedge clk) begin
		if (push.byte_valid | push.stat_valid) begin
			ent_q[wr_q] <= ent0;
		end
		if (push.byte_valid & push.stat_valid) begin
			ent_q[wr_q + tpp_pkg::Q_AW'(1)] <= push.stat_res;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			wr_q <= wr_q + tpp_pkg::Q_AW'(push_n);
			if (pop) begin
				rd_q <= rd_q + tpp_pkg::Q_AW'(1);
			end
			cnt_q <= cnt_q + push_n - tpp_pkg::Q_CW'(pop);
		end
	end

endmodule
